@@ hdl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int MAX_TIMERS_DEF   = 16;
  localparam int HANDLER_BITS_DEF = 8;
  localparam int HANDLER_MAX_W    = 16;
  localparam int RESULT_LIMIT     = 16;
  localparam int ID_W             = 8;
  localparam int LIMIT_W          = 32;
  localparam int REMOVED_W        = 7;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_ADDED   = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_REMOVED = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     keep;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_REMOVE,
    ST_DONE
  } state_t;

endpackage

@@ hdl/ptt_cell.sv @@
// ----------------------------------------------------------------------------
// ptt_cell
// One timer slot; takes its right neighbor, or the bus if last, on a rotate.
// ----------------------------------------------------------------------------
module ptt_cell #(
  parameter int HANDLER_BITS = ptt_pkg::HANDLER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ptt_pkg::cell_ctl_t         ctl,
  input  logic                       left_valid,
  input  logic                       nb_valid,
  input  logic [ptt_pkg::LIMIT_W-1:0] nb_limit,
  input  logic [ptt_pkg::LIMIT_W-1:0] nb_counter,
  input  logic [HANDLER_BITS-1:0]    nb_handler,
  input  logic [ptt_pkg::LIMIT_W-1:0] bus_limit,
  input  logic [ptt_pkg::LIMIT_W-1:0] bus_counter,
  input  logic [HANDLER_BITS-1:0]    bus_handler,
  output logic                       valid,
  output logic [ptt_pkg::LIMIT_W-1:0] limit,
  output logic [ptt_pkg::LIMIT_W-1:0] counter,
  output logic [HANDLER_BITS-1:0]    handler
);
  import ptt_pkg::*;

  logic                    valid_next;
  logic [LIMIT_W-1:0]      limit_next;
  logic [LIMIT_W-1:0]      counter_next;
  logic [HANDLER_BITS-1:0] handler_next;

  always_comb begin
    valid_next   = valid;
    limit_next   = limit;
    counter_next = counter;
    handler_next = handler;
    case (ctl.op)
      OP_ROTATE: begin
        // last valid slot receives the entry that leaves the head
        if (valid && !nb_valid) begin
          valid_next   = ctl.keep;
          limit_next   = bus_limit;
          counter_next = bus_counter;
          handler_next = bus_handler;
        end else begin
          valid_next   = nb_valid;
          limit_next   = nb_limit;
          counter_next = nb_counter;
          handler_next = nb_handler;
        end
      end
      OP_APPEND: begin
        if (!valid && left_valid) begin
          valid_next   = 1'b1;
          limit_next   = bus_limit;
          counter_next = bus_counter;
          handler_next = bus_handler;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    limit   <= limit_next;
    counter <= counter_next;
    handler <= handler_next;
  end

endmodule

@@ hdl/periodic_timer_table.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_table
// Periodic timer table built as a row of slots that rotates through its head.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  cmd     | in        | cmd_valid/cmd_stall | mode, handler_id, interval
//  res     | out       | res_valid/res_stall | kind, fired_id, removed_count, last
//
//  A command beat is taken only while the controller is idle.
//  Add appends the entry and loads its result in the add state. Tick and
//  remove rotate every entry in the table through the head of the slot
//  row, then take a closing step.
//  A stalled result register holds the tick rotation and the add/remove
//  closing step; a remove rotation runs on regardless.
//  Reset (rst, synchronous) empties the table and the result register.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
  parameter int MAX_TIMERS   = ptt_pkg::MAX_TIMERS_DEF,
  parameter int HANDLER_BITS = ptt_pkg::HANDLER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [1:0]                    mode,
  input  logic [ptt_pkg::ID_W-1:0]      handler_id,
  input  logic [ptt_pkg::LIMIT_W-1:0]   interval,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [1:0]                    kind,
  output logic [ptt_pkg::ID_W-1:0]      fired_id,
  output logic [ptt_pkg::REMOVED_W-1:0] removed_count,
  output logic                          last
);
  import ptt_pkg::*;

  localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
  localparam int EMIT_W = $clog2(RESULT_LIMIT + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]        total;
  logic [CNT_W-1:0]        sweep_len;
  logic [CNT_W-1:0]        step;
  logic [CNT_W-1:0]        removed;
  logic [EMIT_W-1:0]       n_emit;
  logic [1:0]              cur_mode;
  logic [HANDLER_BITS-1:0] cur_hid;
  logic [LIMIT_W-1:0]      cur_interval;
  logic                    pend_valid;
  logic [HANDLER_BITS-1:0] pend_id;

  // slot row
  logic                    cv [MAX_TIMERS];
  logic [LIMIT_W-1:0]      cl [MAX_TIMERS];
  logic [LIMIT_W-1:0]      cc [MAX_TIMERS];
  logic [HANDLER_BITS-1:0] ch [MAX_TIMERS];

  cell_ctl_t               ctl;
  logic [LIMIT_W-1:0]      bus_limit;
  logic [LIMIT_W-1:0]      bus_counter;
  logic [HANDLER_BITS-1:0] bus_handler;

  logic                    cmd_accept;
  logic                    res_free;
  logic                    last_step;
  logic                    head_fire;
  logic                    emit;
  logic                    full;
  logic                    res_load;
  logic [1:0]              res_kind_next;
  logic [HANDLER_BITS-1:0] res_id_next;
  logic [REMOVED_W-1:0]    res_removed_next;
  logic                    res_last_next;

  logic [HANDLER_MAX_W-1:0] hid_ext;
  logic [HANDLER_MAX_W-1:0] res_id_ext;

  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_free   = !res_valid || !res_stall;
  assign full       = (total == CNT_W'(MAX_TIMERS));
  assign last_step  = (CNT_W'(step + 1'b1) == sweep_len);
  assign hid_ext    = HANDLER_MAX_W'(handler_id);

  // head of the row: a fired timer restarts at zero, others count up
  assign head_fire = (cc[0] >= cl[0]);
  assign emit      = head_fire && (ch[0] != '0) && (n_emit < EMIT_W'(RESULT_LIMIT));

  always_comb begin
    bus_limit   = cl[0];
    bus_counter = cc[0];
    bus_handler = ch[0];
    case (state)
      ST_TICK: begin
        bus_counter = head_fire ? '0 : cc[0] + 1'b1;
      end
      ST_ADD: begin
        bus_limit   = cur_interval;
        bus_counter = '0;
        bus_handler = cur_hid;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_accept) begin
          case (mode)
            MODE_TICK:   state_next = (total == '0) ? ST_IDLE : ST_TICK;
            MODE_ADD:    state_next = ST_ADD;
            MODE_REMOVE: state_next = (total == '0) ? ST_DONE : ST_REMOVE;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (res_free && last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_REMOVE: begin
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free || (cur_mode == MODE_TICK && !pend_valid)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the controller: row control and result register load
  always_comb begin
    ctl.op           = OP_HOLD;
    ctl.keep         = 1'b1;
    res_load         = 1'b0;
    res_kind_next    = KIND_FIRED;
    res_id_next      = pend_id;
    res_removed_next = '0;
    res_last_next    = 1'b0;
    case (state)
      ST_ADD: begin
        if (res_free) begin
          ctl.op        = full ? OP_HOLD : OP_APPEND;
          res_load      = 1'b1;
          res_kind_next = full ? KIND_FULL : KIND_ADDED;
          res_id_next   = cur_hid;
          res_last_next = 1'b1;
        end
      end
      ST_TICK: begin
        if (res_free) begin
          ctl.op   = OP_ROTATE;
          // hand on the held fire once a later one shows up
          res_load = emit && pend_valid;
        end
      end
      ST_REMOVE: begin
        ctl.op   = OP_ROTATE;
        ctl.keep = (ch[0] != cur_hid);
      end
      ST_DONE: begin
        if (res_free) begin
          res_last_next = 1'b1;
          if (cur_mode == MODE_TICK) begin
            res_load = pend_valid;
          end else begin
            res_load         = 1'b1;
            res_kind_next    = KIND_REMOVED;
            res_id_next      = '0;
            res_removed_next = REMOVED_W'(removed);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      total      <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.op == OP_APPEND) begin
        total <= total + 1'b1;
      end else if (state == ST_REMOVE && !ctl.keep) begin
        total <= total - 1'b1;
      end
      if (cmd_accept) begin
        pend_valid <= 1'b0;
      end else if (state == ST_TICK && res_free && emit) begin
        pend_valid <= 1'b1;
      end else if (state == ST_DONE && res_free) begin
        pend_valid <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      cur_mode     <= mode;
      cur_hid      <= hid_ext[HANDLER_BITS-1:0];
      cur_interval <= interval;
      sweep_len    <= total;
      step         <= '0;
      removed      <= '0;
      n_emit       <= '0;
    end else if (ctl.op == OP_ROTATE) begin
      step <= step + 1'b1;
      if (state == ST_REMOVE && !ctl.keep) begin
        removed <= removed + 1'b1;
      end
      if (state == ST_TICK && emit) begin
        pend_id <= ch[0];
        n_emit  <= n_emit + 1'b1;
      end
    end
    if (res_load) begin
      kind          <= res_kind_next;
      fired_id      <= res_id_ext[ID_W-1:0];
      removed_count <= res_removed_next;
      last          <= res_last_next;
    end
  end

  assign res_id_ext = HANDLER_MAX_W'(res_id_next);

  // row of slots, entry 0 at the head
  for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
    logic                    lv;
    logic                    rv;
    logic [LIMIT_W-1:0]      rl;
    logic [LIMIT_W-1:0]      rc;
    logic [HANDLER_BITS-1:0] rh;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
    end else begin : g_body
      assign lv = cv[i-1];
    end

    if (i == MAX_TIMERS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rl = cl[i];
      assign rc = cc[i];
      assign rh = ch[i];
    end else begin : g_link
      assign rv = cv[i+1];
      assign rl = cl[i+1];
      assign rc = cc[i+1];
      assign rh = ch[i+1];
    end

    ptt_cell #(
      .HANDLER_BITS (HANDLER_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (lv),
      .nb_valid    (rv),
      .nb_limit    (rl),
      .nb_counter  (rc),
      .nb_handler  (rh),
      .bus_limit   (bus_limit),
      .bus_counter (bus_counter),
      .bus_handler (bus_handler),
      .valid       (cv[i]),
      .limit       (cl[i]),
      .counter     (cc[i]),
      .handler     (ch[i])
    );
  end

endmodule

@@ bench/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// ptt_checker
// Watches both channels of the timer table, predicts the result beats of
// every command beat and compares them in order against the block.
// ----------------------------------------------------------------------------
module ptt_checker #(
  parameter int MAX_TIMERS   = ptt_pkg::MAX_TIMERS_DEF,
  parameter int HANDLER_BITS = ptt_pkg::HANDLER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  logic                          cmd_stall,
  input  logic [1:0]                    mode,
  input  logic [ptt_pkg::ID_W-1:0]      handler_id,
  input  logic [ptt_pkg::LIMIT_W-1:0]   interval,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  logic [1:0]                    kind,
  input  logic [ptt_pkg::ID_W-1:0]      fired_id,
  input  logic [ptt_pkg::REMOVED_W-1:0] removed_count,
  input  logic                          last,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << HANDLER_BITS) - 1);

  typedef struct {
    logic [1:0]           kind;
    logic [ID_W-1:0]      id;
    logic [REMOVED_W-1:0] removed;
    logic                 last;
  } timer_result_t;

  // Shadow of the timer table, in insertion order.
  logic [LIMIT_W-1:0] limit_tbl   [MAX_TIMERS];
  logic [LIMIT_W-1:0] counter_tbl [MAX_TIMERS];
  logic [ID_W-1:0]    owner_tbl   [MAX_TIMERS];
  int                 timers_used;

  timer_result_t      due_results[$];
  timer_result_t      want;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_result(input logic [1:0] k, input logic [ID_W-1:0] id,
                             input int removed, input logic fin);
    timer_result_t r;
    r.kind    = k;
    r.id      = id;
    r.removed = REMOVED_W'(removed);
    r.last    = fin;
    due_results.insert(due_results.size(), r);
  endtask

  // Advance the shadow table by one command beat and queue what it emits.
  task automatic run_timer_command(input logic [1:0] m, input logic [ID_W-1:0] hid_in,
                                   input logic [LIMIT_W-1:0] ivl);
    logic [ID_W-1:0] hid;
    logic [ID_W-1:0] held_id;
    bit              have_held;
    int              emitted;
    int              kept;
    int              gone;
    hid       = hid_in & ID_MASK;
    have_held = 1'b0;
    held_id   = '0;
    emitted   = 0;
    kept      = 0;
    gone      = 0;
    case (m)
      MODE_TICK: begin
        for (int i = 0; i < timers_used; i++) begin
          if (counter_tbl[i] >= limit_tbl[i]) begin
            counter_tbl[i] = '0;
            if (owner_tbl[i] != '0 && emitted < RESULT_LIMIT) begin
              // hold each fire back one step so the final one gets last set
              if (have_held) push_result(KIND_FIRED, held_id, 0, 1'b0);
              held_id   = owner_tbl[i];
              have_held = 1'b1;
              emitted++;
            end
          end else begin
            counter_tbl[i] = counter_tbl[i] + 1'b1;
          end
        end
        if (have_held) push_result(KIND_FIRED, held_id, 0, 1'b1);
      end
      MODE_ADD: begin
        if (timers_used >= MAX_TIMERS) begin
          push_result(KIND_FULL, hid, 0, 1'b1);
        end else begin
          limit_tbl[timers_used]   = ivl;
          counter_tbl[timers_used] = '0;
          owner_tbl[timers_used]   = hid;
          timers_used++;
          push_result(KIND_ADDED, hid, 0, 1'b1);
        end
      end
      MODE_REMOVE: begin
        for (int i = 0; i < timers_used; i++) begin
          if (owner_tbl[i] == hid) begin
            gone++;
          end else begin
            limit_tbl[kept]   = limit_tbl[i];
            counter_tbl[kept] = counter_tbl[i];
            owner_tbl[kept]   = owner_tbl[i];
            kept++;
          end
        end
        timers_used = kept;
        push_result(KIND_REMOVED, '0, gone, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timers_used = 0;
      due_results.delete();
      outstanding <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat kind=%0d id=%0d removed=%0d last=%0b",
                                  kind, fired_id, removed_count, last));
        end else begin
          want = due_results.pop_front();
          if (kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
          if (fired_id !== want.id)
            flag_mismatch($sformatf("fired_id %0d, want %0d", fired_id, want.id));
          if (removed_count !== want.removed)
            flag_mismatch($sformatf("removed_count %0d, want %0d",
                                    removed_count, want.removed));
          if (last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
      end
      if (cmd_valid && !cmd_stall) run_timer_command(mode, handler_id, interval);
      outstanding <= due_results.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the periodic timer table: a directed opening over the corner
// cases, then about 480 random commands with random gaps and stalls on both
// channels. A checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int MAX_TIMERS   = MAX_TIMERS_DEF;
  localparam int HANDLER_BITS = HANDLER_BITS_DEF;
  // Mode value the block has no use for; it must be dropped silently.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Cycles the receiver refuses results to back the table up.
  localparam int HOLD_CYCLES = 400;
  // Settle time after the last result, well beyond one full-table pass.
  localparam int DRAIN_CYCLES = 4 * MAX_TIMERS + 8;
  localparam int RANDOM_ITEMS = 480;

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  logic [1:0]           mode;
  logic [ID_W-1:0]      handler_id;
  logic [LIMIT_W-1:0]   interval;
  logic                 res_valid;
  logic                 res_stall;
  logic [1:0]           kind;
  logic [ID_W-1:0]      fired_id;
  logic [REMOVED_W-1:0] removed_count;
  logic                 last;

  int mismatches;
  int outstanding;

  // Shared knobs between the command driver and the result drain.
  bit gaps_on;
  int holds_asked;

  periodic_timer_table #(
    .MAX_TIMERS   (MAX_TIMERS),
    .HANDLER_BITS (HANDLER_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .mode          (mode),
    .handler_id    (handler_id),
    .interval      (interval),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .fired_id      (fired_id),
    .removed_count (removed_count),
    .last          (last)
  );

  ptt_checker #(
    .MAX_TIMERS   (MAX_TIMERS),
    .HANDLER_BITS (HANDLER_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .mode          (mode),
    .handler_id    (handler_id),
    .interval      (interval),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .fired_id      (fired_id),
    .removed_count (removed_count),
    .last          (last),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result drain. Stall at random while gaps are on, never while they are
  // off, and honor every hold-off request with a long solid stall so the
  // table backs up into the command side.
  initial begin : drain
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    res_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= gaps_on && ($urandom_range(99) < 33);
      end
    end
  end

  // Offer one command beat and hold it until the block takes it. Random
  // idle cycles go in front of the beat while gaps are on. The payload
  // changes only at a falling edge and never while the beat is stalled.
  task automatic send_cmd(input logic [1:0] m, input logic [ID_W-1:0] hid,
                          input logic [LIMIT_W-1:0] ivl);
    bit taken;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 33) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid  <= 1'b1;
    mode       <= m;
    handler_id <= hid;
    interval   <= ivl;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      // read before the edge's updates land: this is the value the block saw
      taken = !cmd_stall;
    end
  endtask

  // Drop valid and wait for every predicted result to drain.
  task automatic drain_all;
    @(negedge clk);
    cmd_valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  // Mostly a handful of shared ids so removes find matches, some null
  // handlers, and the odd id from the whole range.
  function automatic logic [ID_W-1:0] pick_handler();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 80) return ID_W'($urandom_range(1, 6));
    return ID_W'($urandom_range(0, (1 << ID_W) - 1));
  endfunction

  initial begin : stimulus
    int              sent;
    int              roll;
    int              tick_pct;
    int              add_pct;
    logic [1:0]      m;
    logic [ID_W-1:0] hid;
    logic [LIMIT_W-1:0] ivl;

    rst         = 1'b1;
    cmd_valid   = 1'b0;
    mode        = MODE_TICK;
    handler_id  = '0;
    interval    = '0;
    gaps_on     = 1'b1;
    holds_asked = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // ---- directed opening ----
    // Tick on an empty table: nothing comes back.
    send_cmd(MODE_TICK, '0, '0);
    // Unused mode: dropped, no beat, table untouched.
    send_cmd(MODE_UNUSED, 8'hFF, '1);
    // Remove with nothing to match: a done beat with a zero count.
    send_cmd(MODE_REMOVE, 8'd7, '0);
    // Null handler, every-tick timer, a timer that never fires, period three.
    send_cmd(MODE_ADD, '0, '0);
    send_cmd(MODE_ADD, 8'hFF, '0);
    send_cmd(MODE_ADD, 8'd1, '1);
    send_cmd(MODE_ADD, 8'd2, 32'd2);
    // Three ticks: the 0xFF timer fires each time, id 2 on the third only,
    // the null handler fires silently.
    repeat (3) send_cmd(MODE_TICK, '0, '0);
    // Fill the table with every-tick timers, then add once more: refused.
    repeat (MAX_TIMERS - 4) send_cmd(MODE_ADD, 8'd3, '0);
    send_cmd(MODE_ADD, 8'd9, 32'd5);
    // Full table tick: a long burst of fires in table order.
    send_cmd(MODE_TICK, '0, '0);
    // Remove the bulk entries and the null handler, closing the gaps.
    send_cmd(MODE_REMOVE, 8'd3, '0);
    send_cmd(MODE_REMOVE, '0, '0);
    send_cmd(MODE_TICK, '0, '0);
    drain_all();

    // ---- random part ----
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Quiet stretch: no gaps on either side.
      if (sent == 160) gaps_on = 1'b0;
      if (sent == 280) gaps_on = 1'b1;
      // Sender pause until the block has handed back everything.
      if (sent == 220) drain_all();
      // Long receiver hold while commands keep coming in.
      if (sent == 330) holds_asked++;

      // Fill window: lean on adds so the table runs full and ticks burst.
      if (sent >= 300 && sent < 380) begin
        tick_pct = 43;
        add_pct  = 93;
      end else begin
        tick_pct = 51;
        add_pct  = 81;
      end

      roll = $urandom_range(99);
      if (roll < 3) m = MODE_UNUSED;
      else if (roll < tick_pct) m = MODE_TICK;
      else if (roll < add_pct) m = MODE_ADD;
      else m = MODE_REMOVE;

      hid  = pick_handler();
      roll = $urandom_range(99);
      if (roll < 70) ivl = LIMIT_W'($urandom_range(0, 3));
      else if (roll < 90) ivl = LIMIT_W'($urandom_range(4, 40));
      else ivl = LIMIT_W'($urandom());

      send_cmd(m, hid, ivl);
      // ignored beats do not count toward the item budget
      if (m != MODE_UNUSED) sent++;
    end

    drain_all();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
